// File: rtl/sda_pkg.sv
// Shared types, constants and fixed-point helpers for the SPH density accumulator.
package sda_pkg;

  localparam int VW = 64;           // value width
  localparam int FB = 32;           // fraction bits
  localparam int CW = VW - 1;       // configuration register width
  localparam int HW = VW / 2;       // partial product operand width
  localparam int PW = 2 * VW;       // full product width
  localparam int QW = FB + 1;       // unit vector quotient width
  localparam int AW = 6;            // APB address width
  localparam int RIW = 3;           // register index width
  localparam int SQ_CW = $clog2(VW);
  localparam int DV_CW = $clog2(QW);

  localparam logic [VW-1:0] FX_ONE  = {{(VW-1){1'b0}}, 1'b1} << FB;
  localparam logic [VW-1:0] FX_HALF = {{(VW-1){1'b0}}, 1'b1} << (FB - 1);
  localparam logic [VW-1:0] VMAX    = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN    = {1'b1, {(VW-1){1'b0}}};

  localparam logic [2:0] MUL_LAST = 3'd4;

  localparam logic OPC_CENTER = 1'b0;

  localparam logic [RIW-1:0] REG_H     = 3'd0;
  localparam logic [RIW-1:0] REG_INV_H = 3'd1;
  localparam logic [RIW-1:0] REG_KSC   = 3'd2;
  localparam logic [RIW-1:0] REG_DT    = 3'd3;
  localparam logic [RIW-1:0] REG_RHO   = 3'd4;

  localparam logic [CW-1:0] RST_H     = 63'd4294967296;
  localparam logic [CW-1:0] RST_INV_H = 63'd4294967296;
  localparam logic [CW-1:0] RST_KSC   = 63'd10937044408;
  localparam logic [CW-1:0] RST_DT    = 63'd4294967;
  localparam logic [CW-1:0] RST_RHO   = 63'd4294967296000;

  typedef struct packed {
    logic [CW-1:0] h;
    logic [CW-1:0] inv_h;
    logic [CW-1:0] k_scale;
    logic [CW-1:0] dt;
    logic [CW-1:0] rho;
  } sda_cfg_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_DIFF, OP_MUL, OP_SQRT, OP_PREP1, OP_PREP2,
    OP_DIV, OP_DOT, OP_T12, OP_ACC, OP_EMIT
  } sda_op_t;

  typedef enum logic [3:0] {
    MS_DX, MS_DY, MS_DZ, MS_Q, MS_Q2, MS_Q3, MS_TT, MS_TTT,
    MS_W, MS_T1, MS_G, MS_IG, MS_C, MS_DOT, MS_T2
  } sda_msel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_DIFF, S_RANGE, S_MDX, S_MDY, S_MDZ, S_SQRT, S_RCHK,
    S_MQ, S_MQ2, S_MQ3, S_PREP1, S_MTT, S_MTTT, S_PREP2, S_MW, S_MT1,
    S_MG, S_MIG, S_MC, S_DIV, S_MDOT, S_DOT, S_MT2, S_T12, S_ACC, S_FINISH
  } sda_state_t;

  typedef struct packed {
    logic      accept;
    sda_op_t   op;
    sda_msel_t msel;
    logic [1:0] k;
  } sda_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic sqrt_done;
    logic div_done;
    logic out_of_range;
    logic r_gt_h;
    logic r_zero;
    logic is_center;
    logic is_last;
    logic out_busy;
  } sda_sts_t;

  // Drop the fraction bits of a full product, saturating to all ones.
  function automatic logic [VW-1:0] fx_trunc(input logic [PW-1:0] p);
    if (|p[PW-1:VW+FB]) return '1;
    return p[VW+FB-1:FB];
  endfunction

  function automatic logic [VW-1:0] sat_sm(input logic neg, input logic [VW-1:0] m);
    if (!neg) return m[VW-1] ? VMAX : m;
    return m[VW-1] ? VMIN : (~m + 1'b1);
  endfunction

  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
    return s[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] sat_sub(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) return s[VW] ? VMIN : VMAX;
    return s[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] times6(input logic [VW-1:0] x);
    return (x << 2) + (x << 1);
  endfunction

endpackage

// File: rtl/sda_mul.sv
// Iterative unsigned multiplier: four 32x32 partial products into a full product.
module sda_mul import sda_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [VW-1:0] a,
  input  logic [VW-1:0] b,
  output logic          done,
  output logic [PW-1:0] prod
);

  logic          busy_r, done_r;
  logic [2:0]    cnt_r;
  logic [VW-1:0] a_r, b_r, pp_r, pp_nxt;
  logic [1:0]    sh_r, sh_nxt;
  logic [PW-1:0] acc_r, acc_nxt, pp_sh;
  logic [HW-1:0] a_h, b_h;

  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin a_h = a_r[HW-1:0];  b_h = b_r[HW-1:0];  sh_nxt = 2'd0; end
      2'd1: begin a_h = a_r[HW-1:0];  b_h = b_r[VW-1:HW]; sh_nxt = 2'd1; end
      2'd2: begin a_h = a_r[VW-1:HW]; b_h = b_r[HW-1:0];  sh_nxt = 2'd1; end
      default: begin a_h = a_r[VW-1:HW]; b_h = b_r[VW-1:HW]; sh_nxt = 2'd2; end
    endcase
  end

  assign pp_nxt = VW'(a_h) * VW'(b_h);

  always_comb begin
    case (sh_r)
      2'd0:    pp_sh = PW'(pp_r);
      2'd1:    pp_sh = PW'(pp_r) << HW;
      default: pp_sh = PW'(pp_r) << VW;
    endcase
  end

  assign acc_nxt = acc_r + pp_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go && !busy_r && !done_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r != MUL_LAST) begin
          pp_r <= pp_nxt;
          sh_r <= sh_nxt;
        end
        if (cnt_r != 3'd0) acc_r <= acc_nxt;
        if (cnt_r == MUL_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: rtl/sda_sqrt.sv
// Digit-by-digit integer square root of the squared distance, two bits an iteration.
module sda_sqrt import sda_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [PW-1:0] n,
  output logic          done,
  output logic [VW-1:0] root
);

  logic             busy_r, done_r;
  logic [SQ_CW-1:0] cnt_r;
  logic [PW-1:0]    n_r;
  logic [VW:0]      rem_r;
  logic [VW-1:0]    root_r;
  logic [VW+2:0]    rem_t, trial, diff;
  logic             ge;

  assign rem_t = {rem_r, n_r[PW-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = rem_t >= trial;
  assign diff  = rem_t - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go && !busy_r && !done_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        n_r    <= n;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[VW:0] : rem_t[VW:0];
        root_r <= {root_r[VW-2:0], ge};
        n_r    <= n_r << 2;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == SQ_CW'(VW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: rtl/sda_div.sv
// Restoring fractional divider: floor(num * 2^FB / den) for num not above den.
module sda_div import sda_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [VW-1:0] num,
  input  logic [VW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);

  logic             busy_r, done_r;
  logic [DV_CW-1:0] cnt_r;
  logic [VW-1:0]    rem_r, den_r, rem_s;
  logic [QW-1:0]    q_r;
  logic             ge;

  // First step compares without a shift: the integer bit of the quotient.
  assign rem_s = (cnt_r == '0) ? rem_r : {rem_r[VW-2:0], 1'b0};
  assign ge    = rem_s >= den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go && !busy_r && !done_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= num;
        den_r  <= den;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? rem_s - den_r : rem_s;
        q_r   <= {q_r[QW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DV_CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// File: rtl/sda_dp.sv
// Datapath: item and centre registers, kernel working registers, shared units, result register.
module sda_dp import sda_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  sda_cmd_t      cmd,
  input  sda_cfg_t      cfg,
  input  logic          in_opcode,
  input  logic [VW-1:0] in_pos_x,
  input  logic [VW-1:0] in_pos_y,
  input  logic [VW-1:0] in_pos_z,
  input  logic [VW-1:0] in_vel_x,
  input  logic [VW-1:0] in_vel_y,
  input  logic [VW-1:0] in_vel_z,
  input  logic [CW-1:0] in_particle_mass,
  input  logic          in_boundary_flag,
  input  logic          in_is_last,
  output sda_sts_t      sts,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [VW-1:0] out_density
);

  logic          opc_r, last_r;
  logic [VW-1:0] pos_r [0:2];
  logic [VW-1:0] vel_r [0:2];
  logic [CW-1:0] mass_r;
  logic [VW-1:0] cpos_r [0:2];
  logic [VW-1:0] cvel_r [0:2];
  logic          cbnd_r;
  logic [VW-1:0] sum_r;

  logic [VW-1:0] dm_r [0:2];
  logic          dn_r [0:2];
  logic [VW-1:0] dm_nxt [0:2];
  logic          dn_nxt [0:2];
  logic [PW-1:0] r2_r;
  logic [VW-1:0] r_r, q_r, q2_r, q3_r, t_r, s1_r, ab_r, tt_r, ttt_r, wa_r, f_r, w_r;
  logic          ab_gt_r;
  logic [VW-1:0] term1_r, term2_r, g_r, ig_r, c_r, um_r, dv_r, pm_r, dot_r, t12_r;
  logic          out_valid_r;
  logic [VW-1:0] out_density_r;

  logic          mul_go, mul_done, sqrt_done, div_done;
  logic [VW-1:0] mul_a, mul_b, fxp, root, a2, b3, s6;
  logic [PW-1:0] prod;
  logic [QW-1:0] quo;
  logic [VW-1:0] h_ext, dv_mag, dot_mag;
  logic          dot_pos;

  assign h_ext   = {1'b0, cfg.h};
  assign dv_mag  = dv_r[VW-1] ? (~dv_r + 1'b1) : dv_r;
  assign dot_mag = dot_r[VW-1] ? (~dot_r + 1'b1) : dot_r;
  assign dot_pos = !dot_r[VW-1] && (dot_r != '0);
  assign fxp     = fx_trunc(prod);
  assign a2      = q_r << 1;
  assign b3      = (q2_r << 1) + q2_r;
  assign s6      = times6(s1_r);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dn_nxt[i] = $signed(cpos_r[i]) < $signed(pos_r[i]);
      dm_nxt[i] = dn_nxt[i] ? pos_r[i] - cpos_r[i] : cpos_r[i] - pos_r[i];
    end
  end

  always_comb begin
    case (cmd.msel)
      MS_DX:   begin mul_a = dm_r[0];           mul_b = dm_r[0]; end
      MS_DY:   begin mul_a = dm_r[1];           mul_b = dm_r[1]; end
      MS_DZ:   begin mul_a = dm_r[2];           mul_b = dm_r[2]; end
      MS_Q:    begin mul_a = r_r;               mul_b = {1'b0, cfg.inv_h}; end
      MS_Q2:   begin mul_a = q_r;               mul_b = q_r; end
      MS_Q3:   begin mul_a = q2_r;              mul_b = q_r; end
      MS_TT:   begin mul_a = t_r;               mul_b = t_r; end
      MS_TTT:  begin mul_a = tt_r;              mul_b = t_r; end
      MS_W:    begin mul_a = {1'b0, cfg.k_scale}; mul_b = wa_r; end
      MS_T1:   begin mul_a = {1'b0, mass_r};    mul_b = w_r; end
      MS_G:    begin mul_a = {1'b0, cfg.k_scale}; mul_b = f_r; end
      MS_IG:   begin mul_a = {1'b0, cfg.inv_h}; mul_b = g_r; end
      MS_C:    begin mul_a = {1'b0, cfg.dt};    mul_b = ig_r; end
      MS_DOT:  begin mul_a = dv_mag;            mul_b = um_r; end
      MS_T2:   begin mul_a = c_r;               mul_b = dot_mag; end
      default: begin mul_a = '0;                mul_b = '0; end
    endcase
  end

  assign mul_go = (cmd.op == OP_MUL);

  sda_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (prod)
  );

  sda_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.op == OP_SQRT),
    .n    (r2_r),
    .done (sqrt_done),
    .root (root)
  );

  sda_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.op == OP_DIV),
    .num  (dm_r[cmd.k]),
    .den  (r_r),
    .done (div_done),
    .quo  (quo)
  );

  // Centre state and running sum reset to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        cpos_r[i] <= '0;
        cvel_r[i] <= '0;
      end
      cbnd_r      <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && cmd.op != OP_EMIT) out_valid_r <= 1'b0;
      if (cmd.accept) begin
        opc_r    <= in_opcode;
        last_r   <= in_is_last;
        pos_r[0] <= in_pos_x;
        pos_r[1] <= in_pos_y;
        pos_r[2] <= in_pos_z;
        vel_r[0] <= in_vel_x;
        vel_r[1] <= in_vel_y;
        vel_r[2] <= in_vel_z;
        mass_r   <= in_particle_mass;
        if (in_opcode == OPC_CENTER) begin
          cpos_r[0] <= in_pos_x;
          cpos_r[1] <= in_pos_y;
          cpos_r[2] <= in_pos_z;
          cvel_r[0] <= in_vel_x;
          cvel_r[1] <= in_vel_y;
          cvel_r[2] <= in_vel_z;
          cbnd_r    <= in_boundary_flag;
          sum_r     <= '0;
        end
      end
      case (cmd.op)
        OP_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            dm_r[i] <= dm_nxt[i];
            dn_r[i] <= dn_nxt[i];
          end
          dot_r   <= '0;
          term2_r <= '0;
        end
        OP_MUL: begin
          if (mul_done) begin
            case (cmd.msel)
              MS_DX:   r2_r <= prod;
              MS_DY:   r2_r <= r2_r + prod;
              MS_DZ:   r2_r <= r2_r + prod;
              MS_Q:    q_r <= (fxp > FX_ONE) ? FX_ONE : fxp;
              MS_Q2:   q2_r <= fxp;
              MS_Q3:   q3_r <= fxp;
              MS_TT:   tt_r <= fxp;
              MS_TTT:  ttt_r <= fxp;
              MS_W:    w_r <= fxp;
              MS_T1:   term1_r <= sat_sm(1'b0, fxp);
              MS_G:    g_r <= fxp;
              MS_IG:   ig_r <= fxp;
              MS_C:    c_r <= fxp;
              MS_DOT:  pm_r <= sat_sm(dv_r[VW-1] ^ dn_r[cmd.k], fxp);
              MS_T2:   term2_r <= sat_sm(dot_pos, fxp);
              default: ;
            endcase
          end
        end
        OP_SQRT: begin
          if (sqrt_done) r_r <= root;
        end
        OP_PREP1: begin
          s1_r    <= q2_r - q3_r;
          ab_gt_r <= a2 > b3;
          ab_r    <= a2 - b3;
          t_r     <= FX_ONE - q_r;
        end
        OP_PREP2: begin
          if (q_r <= FX_HALF) begin
            wa_r <= (s6 > FX_ONE) ? '0 : FX_ONE - s6;
            f_r  <= ab_gt_r ? times6(ab_r) : '0;
          end else begin
            wa_r <= ttt_r << 1;
            f_r  <= times6(tt_r);
          end
        end
        OP_DIV: begin
          dv_r <= sat_sub(cvel_r[cmd.k], vel_r[cmd.k]);
          if (div_done) um_r <= VW'(quo);
        end
        OP_DOT:  dot_r <= sat_add(dot_r, pm_r);
        OP_T12:  t12_r <= sat_add(term1_r, term2_r);
        OP_ACC:  sum_r <= sat_add(sum_r, t12_r);
        OP_EMIT: begin
          out_valid_r   <= 1'b1;
          out_density_r <= cbnd_r ? {1'b0, cfg.rho} : sum_r;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.mul_done     = mul_done;
    sts.sqrt_done    = sqrt_done;
    sts.div_done     = div_done;
    sts.out_of_range = (dm_r[0] > h_ext) || (dm_r[1] > h_ext) || (dm_r[2] > h_ext);
    sts.r_gt_h       = r_r > h_ext;
    sts.r_zero       = (r_r == '0);
    sts.is_center    = (opc_r == OPC_CENTER);
    sts.is_last      = last_r;
    sts.out_busy     = out_valid_r && !out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_density = out_density_r;

endmodule

// File: rtl/sda_ctrl.sv
// Controller: sequences one item through the datapath steps.
module sda_ctrl import sda_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sda_sts_t sts,
  output sda_cmd_t cmd
);

  sda_state_t state_r, state_nxt;
  logic [1:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: state_nxt = sts.is_center ? S_FINISH : S_DIFF;
      S_DIFF:     state_nxt = S_RANGE;
      S_RANGE:    state_nxt = sts.out_of_range ? S_FINISH : S_MDX;
      S_MDX:      if (sts.mul_done) state_nxt = S_MDY;
      S_MDY:      if (sts.mul_done) state_nxt = S_MDZ;
      S_MDZ:      if (sts.mul_done) state_nxt = S_SQRT;
      S_SQRT:     if (sts.sqrt_done) state_nxt = S_RCHK;
      S_RCHK:     state_nxt = sts.r_gt_h ? S_FINISH : S_MQ;
      S_MQ:       if (sts.mul_done) state_nxt = S_MQ2;
      S_MQ2:      if (sts.mul_done) state_nxt = S_MQ3;
      S_MQ3:      if (sts.mul_done) state_nxt = S_PREP1;
      S_PREP1:    state_nxt = S_MTT;
      S_MTT:      if (sts.mul_done) state_nxt = S_MTTT;
      S_MTTT:     if (sts.mul_done) state_nxt = S_PREP2;
      S_PREP2:    state_nxt = S_MW;
      S_MW:       if (sts.mul_done) state_nxt = S_MT1;
      S_MT1:      if (sts.mul_done) state_nxt = sts.r_zero ? S_T12 : S_MG;
      S_MG:       if (sts.mul_done) state_nxt = S_MIG;
      S_MIG:      if (sts.mul_done) state_nxt = S_MC;
      S_MC: begin
        if (sts.mul_done) begin
          state_nxt = S_DIV;
          k_nxt     = 2'd0;
        end
      end
      S_DIV:      if (sts.div_done) state_nxt = S_MDOT;
      S_MDOT:     if (sts.mul_done) state_nxt = S_DOT;
      S_DOT: begin
        if (k_r == 2'd2) begin
          state_nxt = S_MT2;
        end else begin
          state_nxt = S_DIV;
          k_nxt     = k_r + 2'd1;
        end
      end
      S_MT2:      if (sts.mul_done) state_nxt = S_T12;
      S_T12:      state_nxt = S_ACC;
      S_ACC:      state_nxt = S_FINISH;
      S_FINISH:   if (!sts.is_last || !sts.out_busy) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == S_IDLE);
    cmd.accept = in_ready && in_valid;
    cmd.k      = k_r;
    cmd.op     = OP_IDLE;
    cmd.msel   = MS_DX;
    unique case (state_r)
      S_DIFF:  cmd.op = OP_DIFF;
      S_MDX:   begin cmd.op = OP_MUL; cmd.msel = MS_DX;  end
      S_MDY:   begin cmd.op = OP_MUL; cmd.msel = MS_DY;  end
      S_MDZ:   begin cmd.op = OP_MUL; cmd.msel = MS_DZ;  end
      S_SQRT:  cmd.op = OP_SQRT;
      S_MQ:    begin cmd.op = OP_MUL; cmd.msel = MS_Q;   end
      S_MQ2:   begin cmd.op = OP_MUL; cmd.msel = MS_Q2;  end
      S_MQ3:   begin cmd.op = OP_MUL; cmd.msel = MS_Q3;  end
      S_PREP1: cmd.op = OP_PREP1;
      S_MTT:   begin cmd.op = OP_MUL; cmd.msel = MS_TT;  end
      S_MTTT:  begin cmd.op = OP_MUL; cmd.msel = MS_TTT; end
      S_PREP2: cmd.op = OP_PREP2;
      S_MW:    begin cmd.op = OP_MUL; cmd.msel = MS_W;   end
      S_MT1:   begin cmd.op = OP_MUL; cmd.msel = MS_T1;  end
      S_MG:    begin cmd.op = OP_MUL; cmd.msel = MS_G;   end
      S_MIG:   begin cmd.op = OP_MUL; cmd.msel = MS_IG;  end
      S_MC:    begin cmd.op = OP_MUL; cmd.msel = MS_C;   end
      S_DIV:   cmd.op = OP_DIV;
      S_MDOT:  begin cmd.op = OP_MUL; cmd.msel = MS_DOT; end
      S_DOT:   cmd.op = OP_DOT;
      S_MT2:   begin cmd.op = OP_MUL; cmd.msel = MS_T2;  end
      S_T12:   cmd.op = OP_T12;
      S_ACC:   cmd.op = OP_ACC;
      S_FINISH: if (sts.is_last && !sts.out_busy) cmd.op = OP_EMIT;
      default: ;
    endcase
  end

endmodule

// File: rtl/sph_density_accumulator_core.sv
// Top level: configuration registers, controller, datapath and checks.
// SPH predicted-density accumulator, cubic spline kernel, signed Q32.32. A centre item
// (opcode 0) loads the particle and clears the sum; neighbour items add mass*W(r) plus
// dt*(vi-vj).gradW. An item with is_last set gives one density result, held in an output
// register so the next item is taken while it waits. One item is worked on at a time;
// a neighbour out of range on any axis, or beyond h after the square root, ends early.
// One within h uses the shared multiplier for seventeen 64x64 products, each built
// from four 32x32 partial products, plus the 64-iteration square root and three
// 33-iteration divisions.
// Registers sit at byte address 8*i: h, 1/h, kernel scale, dt, rest density.
module sph_density_accumulator_core import sda_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_opcode,
  input  logic [VW-1:0] in_pos_x,
  input  logic [VW-1:0] in_pos_y,
  input  logic [VW-1:0] in_pos_z,
  input  logic [VW-1:0] in_vel_x,
  input  logic [VW-1:0] in_vel_y,
  input  logic [VW-1:0] in_vel_z,
  input  logic [CW-1:0] in_particle_mass,
  input  logic          in_boundary_flag,
  input  logic          in_is_last,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [VW-1:0] out_density,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [VW-1:0] pwdata,
  output logic [VW-1:0] prdata,
  output logic          pready
);

  sda_cfg_t       cfg_r;
  sda_cmd_t       cmd;
  sda_sts_t       sts;
  logic           wr_en;
  logic [RIW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AW-1:AW-RIW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.h       <= RST_H;
      cfg_r.inv_h   <= RST_INV_H;
      cfg_r.k_scale <= RST_KSC;
      cfg_r.dt      <= RST_DT;
      cfg_r.rho     <= RST_RHO;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_H:     cfg_r.h       <= pwdata[CW-1:0];
        REG_INV_H: cfg_r.inv_h   <= pwdata[CW-1:0];
        REG_KSC:   cfg_r.k_scale <= pwdata[CW-1:0];
        REG_DT:    cfg_r.dt      <= pwdata[CW-1:0];
        REG_RHO:   cfg_r.rho     <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_H:     prdata = {1'b0, cfg_r.h};
      REG_INV_H: prdata = {1'b0, cfg_r.inv_h};
      REG_KSC:   prdata = {1'b0, cfg_r.k_scale};
      REG_DT:    prdata = {1'b0, cfg_r.dt};
      REG_RHO:   prdata = {1'b0, cfg_r.rho};
      default:   prdata = '0;
    endcase
  end

  sda_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  sda_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg             (cfg_r),
    .in_opcode       (in_opcode),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_vel_x        (in_vel_x),
    .in_vel_y        (in_vel_y),
    .in_vel_z        (in_vel_z),
    .in_particle_mass(in_particle_mass),
    .in_boundary_flag(in_boundary_flag),
    .in_is_last      (in_is_last),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_density     (out_density)
  );

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready the cycle after an item was taken");

  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> !(out_valid && !out_ready))
    else $error("result register overwritten while its item waits");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.op == OP_EMIT))
    else $error("result raised without an emit step");
`endif

endmodule

// File: verif/tb_sph_density_accumulator_core.sv
// Self-checking testbench for the SPH density accumulator core.
module tb_sph_density_accumulator_core import sda_pkg::*; ();

  localparam logic [63:0] ONE   = 64'h1_0000_0000;
  localparam logic [63:0] MAXU  = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MINS  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] RHO0  = 64'd4294967296000;
  localparam int          DRAIN = 400;

  typedef struct {
    logic        op;
    logic [63:0] px, py, pz, vx, vy, vz;
    logic [62:0] mass;
    logic        bnd, last;
    logic        typed;
    logic [63:0] want;
  } sph_item_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_opcode, in_boundary_flag, in_is_last;
  logic [63:0] in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z;
  logic [62:0] in_particle_mass;
  logic out_valid, out_ready;
  logic [63:0] out_density;
  logic psel, penable, pwrite, pready;
  logic [AW-1:0] paddr;
  logic [63:0] pwdata, prdata;

  sph_density_accumulator_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y), .in_vel_z(in_vel_z),
    .in_particle_mass(in_particle_mass), .in_boundary_flag(in_boundary_flag),
    .in_is_last(in_is_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_density(out_density),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [63:0] c_pos [3];
  logic [63:0] c_vel [3];
  logic        c_bnd;
  logic [63:0] dens_sum;
  logic [63:0] r_h, r_inv_h, r_ksc, r_dt, r_rho;

  logic [63:0] density_q [$];
  int mismatches, results_seen, items_sent, centres_sent, neighbours_sent;
  int tx_idle, rx_idle, hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Timeout waiting for the block");
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] mul_q(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (|p[127:96]) return '1;
    return p[95:32];
  endfunction

  function automatic logic [63:0] sat_mag(logic neg, logic [63:0] m);
    if (!neg) return (m > MAXU) ? MAXU : m;
    if (m > MAXU) return MINS;
    return 64'd0 - m;
  endfunction

  function automatic logic [63:0] magn(logic [63:0] a);
    return a[63] ? 64'd0 - a : a;
  endfunction

  function automatic logic [63:0] add_mag(logic na, logic [63:0] ma, logic nb, logic [63:0] mb);
    logic [63:0] s;
    if (na == nb) begin
      s = ma + mb;
      if (s < ma) s = '1;
      return sat_mag(na, s);
    end
    if (ma >= mb) return sat_mag(na, ma - mb);
    return sat_mag(nb, mb - ma);
  endfunction

  function automatic logic [63:0] add_s(logic [63:0] a, logic [63:0] b);
    return add_mag(a[63], magn(a), b[63], magn(b));
  endfunction

  function automatic logic [63:0] sub_s(logic [63:0] a, logic [63:0] b);
    return add_mag(a[63], magn(a), !b[63], magn(b));
  endfunction

  function automatic logic [63:0] mul_s(logic [63:0] a, logic [63:0] b);
    return sat_mag(a[63] ^ b[63], mul_q(magn(a), magn(b)));
  endfunction

  function automatic logic [63:0] root_floor(logic [127:0] n);
    logic [63:0] res, cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (({64'd0, cand} * {64'd0, cand}) <= n) res = cand;
    end
    return res;
  endfunction

  function automatic logic [63:0] unit_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo, rem;
    quo = '0;
    rem = num;
    if (rem >= den) begin
      rem = rem - den;
      quo = 64'd1;
    end
    repeat (FB) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // Contribution of one neighbour, folded into the running density sum.
  function automatic void add_neighbour_density(sph_item_t it);
    logic [63:0] p [3], v [3], d [3], dm [3];
    logic [127:0] r2;
    logic [63:0] r, q, q2, q3, w, f, g, c, t, s, a, b, term1, term2, dot, um;
    p[0] = it.px; p[1] = it.py; p[2] = it.pz;
    v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
    r2 = '0;
    term2 = '0;
    dot = '0;
    for (int k = 0; k < 3; k++) begin
      if ($signed(c_pos[k]) < $signed(p[k])) begin
        dm[k] = p[k] - c_pos[k];
        d[k] = 64'd0 - dm[k];
      end else begin
        dm[k] = c_pos[k] - p[k];
        d[k] = dm[k];
      end
      if (dm[k] > r_h) return;
      r2 = r2 + {64'd0, dm[k]} * {64'd0, dm[k]};
    end
    r = root_floor(r2);
    if (r > r_h) return;
    q = mul_q(r, r_inv_h);
    if (q > ONE) q = ONE;
    q2 = mul_q(q, q);
    q3 = mul_q(q2, q);
    if (q <= FX_HALF) begin
      s = 64'(6 * (q2 - q3));
      w = mul_q(r_ksc, (s > ONE) ? 64'd0 : ONE - s);
    end else begin
      t = ONE - q;
      w = mul_q(r_ksc, 64'(2 * mul_q(mul_q(t, t), t)));
    end
    term1 = sat_mag(1'b0, mul_q({1'b0, it.mass}, w));
    if (r != 0) begin
      if (q <= FX_HALF) begin
        a = 64'(2 * q);
        b = 64'(3 * q2);
        f = (a > b) ? 64'(6 * (a - b)) : 64'd0;
      end else begin
        t = ONE - q;
        f = 64'(6 * mul_q(t, t));
      end
      g = mul_q(r_ksc, f);
      c = mul_q(r_dt, mul_q(r_inv_h, g));
      for (int k = 0; k < 3; k++) begin
        um = unit_div(magn(d[k]), r);
        dot = add_s(dot, mul_s(sub_s(c_vel[k], v[k]), sat_mag(d[k][63], um)));
      end
      term2 = sat_mag(!dot[63] && dot != 0, mul_q(c, magn(dot)));
    end
    dens_sum = add_s(dens_sum, add_s(term1, term2));
  endfunction

  // Update the predicted state for an accepted item and queue any result.
  function automatic void predict_density(sph_item_t it);
    logic [63:0] res;
    if (it.op == OPC_CENTER) begin
      c_pos[0] = it.px; c_pos[1] = it.py; c_pos[2] = it.pz;
      c_vel[0] = it.vx; c_vel[1] = it.vy; c_vel[2] = it.vz;
      c_bnd = it.bnd;
      dens_sum = '0;
      centres_sent++;
    end else begin
      add_neighbour_density(it);
      neighbours_sent++;
    end
    items_sent++;
    if (!it.last) return;
    res = c_bnd ? r_rho : dens_sum;
    if (it.typed && it.want != res)
      $display("Table value %h differs from prediction %h", it.want, res);
    density_q.push_back(it.typed ? it.want : res);
  endfunction

  // Compare each delivered density with the oldest prediction.
  always @(posedge clk) begin
    logic [63:0] want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (density_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected density %h", out_density);
      end else begin
        want = density_q.pop_front();
        if (want !== out_density) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Density mismatch: expected %h, got %h", want, out_density);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic send_item(sph_item_t it);
    in_valid <= 1'b1;
    in_opcode <= it.op;
    in_pos_x <= it.px; in_pos_y <= it.py; in_pos_z <= it.pz;
    in_vel_x <= it.vx; in_vel_y <= it.vy; in_vel_z <= it.vz;
    in_particle_mass <= it.mass;
    in_boundary_flag <= it.bnd;
    in_is_last <= it.last;
    do @(posedge clk); while (!in_ready);
    predict_density(it);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
  endtask

  // Let the block finish: all results in, then its longest neighbour time.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (density_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [RIW-1:0] idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AW'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_H:     r_h = val & MAXU;
      REG_INV_H: r_inv_h = val & MAXU;
      REG_KSC:   r_ksc = val & MAXU;
      REG_DT:    r_dt = val & MAXU;
      REG_RHO:   r_rho = val & MAXU;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [63:0] h, logic [63:0] ih, logic [63:0] ks,
                            logic [63:0] dt, logic [63:0] rho);
    write_reg(REG_H, h);
    write_reg(REG_INV_H, ih);
    write_reg(REG_KSC, ks);
    write_reg(REG_DT, dt);
    write_reg(REG_RHO, rho);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic sph_item_t mk(logic op, logic [63:0] px, logic [63:0] py,
                                   logic [63:0] pz, logic [63:0] vx, logic [63:0] vy,
                                   logic [63:0] vz, logic [62:0] m, logic bnd,
                                   logic last, logic typed, logic [63:0] want);
    sph_item_t it;
    it.op = op; it.px = px; it.py = py; it.pz = pz;
    it.vx = vx; it.vy = vy; it.vz = vz;
    it.mass = m; it.bnd = bnd; it.last = last; it.typed = typed; it.want = want;
    return it;
  endfunction

  // Offset uniformly within a little more than h on each axis.
  function automatic logic [63:0] near_offset();
    logic [63:0] span;
    span = r_h + (r_h >> 3);
    if (span > 64'h3fff_ffff_ffff_ffff) return rnd64();
    return (rnd64() % (2 * span + 1)) - span;
  endfunction

  function automatic logic [63:0] rnd_vel();
    logic [63:0] v;
    v = rnd64();
    if ($urandom_range(3) != 0) v = {{28{v[35]}}, v[35:0]};
    return v;
  endfunction

  function automatic logic [62:0] rnd_mass();
    logic [62:0] m;
    m = 63'(rnd64());
    if ($urandom_range(3) != 0) m = m & 63'h0000_00ff_ffff_ffff;
    return m;
  endfunction

  // One particle: a centre then a few neighbours, or a noise item.
  task automatic send_particle();
    sph_item_t it;
    int n;
    logic [63:0] cx, cy, cz;
    if ($urandom_range(9) == 0) begin
      it = mk(1'($urandom), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(),
              63'(rnd64()), 1'($urandom), 1'($urandom), 1'b0, '0);
      send_item(it);
      return;
    end
    cx = {{24{1'b0}}, $urandom, 8'h0} - 64'h0000_0080_0000_0000;
    cy = {{24{1'b0}}, $urandom, 8'h0} - 64'h0000_0080_0000_0000;
    cz = {{24{1'b0}}, $urandom, 8'h0} - 64'h0000_0080_0000_0000;
    n = $urandom_range(5);
    it = mk(OPC_CENTER, cx, cy, cz, rnd_vel(), rnd_vel(), rnd_vel(), rnd_mass(),
            ($urandom_range(5) == 0), (n == 0), 1'b0, '0);
    send_item(it);
    for (int i = 0; i < n; i++) begin
      it = mk(1'b1, cx + near_offset(), cy + near_offset(), cz + near_offset(),
              rnd_vel(), rnd_vel(), rnd_vel(), rnd_mass(), 1'($urandom), (i == n - 1),
              1'b0, '0);
      send_item(it);
    end
  endtask

  sph_item_t table_rows [$];

  initial begin
    int phase_items;
    rst_n = 1'b0;
    in_valid = 1'b0; in_opcode = 1'b0; in_boundary_flag = 1'b0; in_is_last = 1'b0;
    in_pos_x = '0; in_pos_y = '0; in_pos_z = '0;
    in_vel_x = '0; in_vel_y = '0; in_vel_z = '0;
    in_particle_mass = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0; results_seen = 0; items_sent = 0;
    centres_sent = 0; neighbours_sent = 0; hold_cycles = 0;
    tx_idle = 31; rx_idle = 50;
    for (int k = 0; k < 3; k++) begin
      c_pos[k] = '0;
      c_vel[k] = '0;
    end
    c_bnd = 1'b0; dens_sum = '0;
    r_h = RST_H; r_inv_h = RST_INV_H; r_ksc = RST_KSC; r_dt = RST_DT; r_rho = RST_RHO;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // neighbour before any centre, at zero distance from the reset state
    table_rows.push_back(mk(1, 0, 0, 0, 0, 0, 0, ONE, 0, 1, 0, 0));
    table_rows.push_back(mk(OPC_CENTER, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 64'd0));
    table_rows.push_back(mk(OPC_CENTER, 5, 6, 7, 1, 2, 3, 0, 1, 1, 1, RHO0));
    // boundary particle still sums its neighbours but reports rest density
    table_rows.push_back(mk(1, 5, 6, 7, 0, 0, 0, ONE, 0, 1, 1, RHO0));
    table_rows.push_back(mk(OPC_CENTER, 0, 0, 0, ONE, 0, MINS, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(1, 2 * ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 0, 0));
    table_rows.push_back(mk(1, ONE >> 2, 0, 0, 64'd0 - ONE, 0, 0, ONE, 0, 0, 0, 0));
    table_rows.push_back(mk(1, 0, 3 * (ONE >> 2), 0, 0, ONE, 0, ONE, 1, 1, 0, 0));
    // more neighbours after the result go into the same sum
    table_rows.push_back(mk(1, 0, 0, ONE, MAXU, MINS, MAXU, ONE, 0, 1, 0, 0));
    table_rows.push_back(mk(1, ONE >> 1, ONE >> 2, ONE >> 3, 0, 0, 0, '1, 0, 1, 0, 0));
    table_rows.push_back(mk(OPC_CENTER, MAXU, MAXU, MAXU, MAXU, MAXU, MAXU, '1, 0, 0,
                            0, 0));
    table_rows.push_back(mk(1, MINS, MINS, MINS, MINS, MINS, MINS, '1, 1, 1, 1, 64'd0));
    table_rows.push_back(mk(OPC_CENTER, '1, '1, '1, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(1, 0, 0, 0, '1, '1, '1, '1, 0, 1, 0, 0));
    foreach (table_rows[i]) send_item(table_rows[i]);

    // extreme settings, each on a centre and two neighbours sent after the table
    wait_idle();
    set_config(1, MAXU, MAXU, MAXU, 0);
    send_item(mk(OPC_CENTER, 0, 0, 0, MAXU, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(1, 0, 0, 0, 0, 0, 0, '1, 0, 0, 0, 0));
    send_item(mk(1, 1, 1, 0, MINS, 0, 0, '1, 0, 1, 0, 0));
    wait_idle();
    set_config(MAXU, 1, 0, 0, MAXU);
    send_item(mk(OPC_CENTER, MAXU, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(1, MINS, MINS, 0, ONE, 0, 0, ONE, 0, 0, 0, 0));
    send_item(mk(1, 0, 0, 0, 0, 0, 0, ONE, 0, 1, 0, 0));

    // random phases, each under its own settings
    phase_items = items_sent;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: set_config(RST_H, RST_INV_H, RST_KSC, RST_DT, RST_RHO);
        1: set_config(ONE >> 1, ONE << 1, 64'd87496355264, ONE >> 4, ONE);
        2: set_config(ONE << 1, ONE >> 1, 64'd1367130551, rnd64(), rnd64());
        3: set_config(1, MAXU, MAXU, MAXU, 0);
        4: set_config(MAXU, 1, 0, 0, MAXU);
        default: set_config(rnd64() >> 28, rnd64() >> 28, rnd64() >> 24,
                            rnd64() >> 30, rnd64());
      endcase
      if (ph == 0) hold_cycles = 3000;
      while (items_sent - phase_items < 90 * (ph + 1)) begin
        if (items_sent - phase_items > 360) begin
          tx_idle = 0; rx_idle = 0;
        end else if (items_sent - phase_items > 180) begin
          tx_idle = 50; rx_idle = 31;
        end
        send_particle();
      end
    end

    in_valid <= 1'b0;
    while (density_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d items (%0d centres, %0d neighbours) under reset, extreme and random settings,",
             items_sent, centres_sent, neighbours_sent);
    $display("checked %0d density results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && density_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sda_pkg.sv
rtl/sda_mul.sv
rtl/sda_sqrt.sv
rtl/sda_div.sv
rtl/sda_dp.sv
rtl/sda_ctrl.sv
rtl/sph_density_accumulator_core.sv
verif/tb_sph_density_accumulator_core.sv
